/* rtl/tdf_pkg.sv */
package tdf_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER = 2'd2;

    localparam logic [19:0] SPEED_RST  = 20'd200;
    localparam logic [23:0] STEP_RST   = 24'd234881;
    localparam logic [3:0]  FILTER_RST = 4'd5;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL,
        OP_HH,
        OP_D,
        OP_A0,
        OP_Y,
        OP_T,
        OP_SQI,
        OP_SQ,
        OP_A,
        OP_M,
        OP_DVI,
        OP_DV,
        OP_FH,
        OP_X1,
        OP_X2
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] part;
        logic       tail;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

endpackage

/* rtl/tdf_ctrl.sv */
module tdf_ctrl #(
    parameter int FRAC_BITS = tdf_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  tdf_pkg::stat_t stat,
    output tdf_pkg::cmd_t  cmd
);

    localparam int DIV_STEPS = 64 + FRAC_BITS;
    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] MUL_LAST   = CNT_W'(3);
    localparam logic [CNT_W-1:0] SQ_LAST    = CNT_W'(63);
    localparam logic [CNT_W-1:0] TAIL_START = CNT_W'(64);
    localparam logic [CNT_W-1:0] DV_LAST    = CNT_W'(DIV_STEPS - 1);

    typedef enum logic [15:0] {
        S_IDLE = 16'h0001,
        S_MUL  = 16'h0002,
        S_HH   = 16'h0004,
        S_D    = 16'h0008,
        S_A0   = 16'h0010,
        S_Y    = 16'h0020,
        S_T    = 16'h0040,
        S_SQI  = 16'h0080,
        S_SQ   = 16'h0100,
        S_A    = 16'h0200,
        S_M    = 16'h0400,
        S_DVI  = 16'h0800,
        S_DV   = 16'h1000,
        S_FH   = 16'h2000,
        S_X1   = 16'h4000,
        S_X2   = 16'h8000
    } state_t;

    state_t           state_reg, state_next;
    state_t           ret_reg, ret_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cnt_next   = cnt_reg + CNT_W'(1);
        cmd.op     = tdf_pkg::OP_NOP;
        cmd.part   = cnt_reg[1:0];
        cmd.tail   = (cnt_reg >= TAIL_START);
        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                begin
                    cmd.op     = tdf_pkg::OP_LOAD;
                    state_next = S_MUL;
                    ret_next   = S_HH;
                end
            end
            S_MUL:
            begin
                cmd.op = tdf_pkg::OP_MUL;
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = ret_reg;
                    cnt_next   = '0;
                end
            end
            S_HH:
            begin
                cmd.op     = tdf_pkg::OP_HH;
                cnt_next   = '0;
                state_next = S_MUL;
                ret_next   = S_D;
            end
            S_D:
            begin
                cmd.op     = tdf_pkg::OP_D;
                cnt_next   = '0;
                state_next = S_MUL;
                ret_next   = S_A0;
            end
            S_A0:
            begin
                cmd.op     = tdf_pkg::OP_A0;
                state_next = S_Y;
            end
            S_Y:
            begin
                cmd.op     = tdf_pkg::OP_Y;
                state_next = S_T;
            end
            S_T:
            begin
                cmd.op     = tdf_pkg::OP_T;
                cnt_next   = '0;
                state_next = S_MUL;
                ret_next   = S_SQI;
            end
            S_SQI:
            begin
                cmd.op     = tdf_pkg::OP_SQI;
                cnt_next   = '0;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.op = tdf_pkg::OP_SQ;
                if (cnt_reg == SQ_LAST)
                begin
                    state_next = S_A;
                end
            end
            S_A:
            begin
                cmd.op     = tdf_pkg::OP_A;
                state_next = S_M;
            end
            S_M:
            begin
                cmd.op     = tdf_pkg::OP_M;
                cnt_next   = '0;
                state_next = S_MUL;
                ret_next   = S_DVI;
            end
            S_DVI:
            begin
                cmd.op     = tdf_pkg::OP_DVI;
                cnt_next   = '0;
                state_next = S_DV;
            end
            S_DV:
            begin
                cmd.op = tdf_pkg::OP_DV;
                if (cnt_reg == DV_LAST)
                begin
                    state_next = S_FH;
                end
            end
            S_FH:
            begin
                cmd.op     = tdf_pkg::OP_FH;
                cnt_next   = '0;
                state_next = S_MUL;
                ret_next   = S_X1;
            end
            S_X1:
            begin
                cmd.op     = tdf_pkg::OP_X1;
                cnt_next   = '0;
                state_next = S_MUL;
                ret_next   = S_X2;
            end
            S_X2:
            begin
                // hold until the output register can take the word
                if (stat.out_free)
                begin
                    cmd.op     = tdf_pkg::OP_X2;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* rtl/tdf_datapath.sv */
module tdf_datapath #(
    parameter int FRAC_BITS = tdf_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tdf_pkg::cmd_t                     cmd,
    output tdf_pkg::stat_t                    stat,
    input  logic                              cfg_we,
    input  logic [tdf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tdf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic signed [31:0]                target_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [31:0]                tracked_value,
    output logic signed [47:0]                tracked_rate,
    output logic signed [47:0]                acceleration
);

    localparam int DSH = 24 - FRAC_BITS;
    localparam logic signed [63:0] WLIM = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [65:0] WLIM_W = 66'sh0_3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [65:0] HI32 = 66'sd2147483647;
    localparam logic signed [65:0] LO32 = -66'sd2147483648;
    localparam logic signed [65:0] HI48 = 66'sd140737488355327;
    localparam logic signed [65:0] LO48 = -66'sd140737488355328;

    function automatic logic signed [63:0] clampw(input logic signed [65:0] x);
        logic signed [63:0] res;
        if (x > WLIM_W)
            res = WLIM;
        else if (x < -WLIM_W)
            res = -WLIM;
        else
            res = x[63:0];
        return res;
    endfunction

    // product of a magnitude and a Q0.24 factor, back to signed, saturated
    function automatic logic signed [63:0] sat24(input logic [127:0] p, input logic neg);
        logic [63:0] m;
        m = (|p[127:86]) ? WLIM : {2'b00, p[85:24]};
        return neg ? -$signed(m) : $signed(m);
    endfunction

    // configuration and tracker state
    logic [19:0]        speed_reg;
    logic [23:0]        step_reg;
    logic [3:0]         filter_reg;
    logic signed [31:0] x1_reg, x1_next;
    logic signed [47:0] x2_reg, x2_next;
    logic               out_valid_reg, out_valid_next;

    // working registers
    logic signed [31:0] v_reg, v_next;
    logic [27:0]        h0_reg, h0_next;
    logic [63:0]        d_reg, d_next;
    logic signed [63:0] a0_reg, a0_next;
    logic signed [63:0] y_reg, y_next;
    logic signed [63:0] a_reg, a_next;
    logic signed [47:0] fh_reg, fh_next;
    logic signed [31:0] x1n_reg, x1n_next;
    logic [127:0]       acc_reg, acc_next;
    logic [63:0]        ma_reg, ma_next;
    logic [63:0]        mb_reg, mb_next;
    logic [63:0]        root_reg, root_next;
    logic [67:0]        rem_reg, rem_next;
    logic [63:0]        q_reg, q_next;
    logic signed [31:0] tv_reg, tv_next;
    logic signed [47:0] tr_reg, tr_next;
    logic signed [47:0] ac_reg, ac_next;

    logic [27:0]        h0_c;
    logic [31:0]        a_half, b_half;
    logic [63:0]        pp;
    logic [1:0]         pp_pos;
    logic [127:0]       pp_sh;
    logic [63:0]        x2_mag, y_mag, a_mag, fh_mag, t_c;
    logic [67:0]        sq_rem, sq_trial, dv_rem;
    logic               dv_bit, dv_ge;
    logic signed [65:0] a_half_dif, a_term, sum_w;
    logic signed [63:0] fh_w;
    logic               fsy, fsa;

    assign h0_c   = 28'(filter_reg) * 28'(step_reg);
    assign a_half = cmd.part[1] ? ma_reg[63:32] : ma_reg[31:0];
    assign b_half = cmd.part[0] ? mb_reg[63:32] : mb_reg[31:0];
    assign pp     = a_half * b_half;
    assign pp_pos = {1'b0, cmd.part[1]} + {1'b0, cmd.part[0]};

    always_comb
    begin
        case (pp_pos)
            2'd0:    pp_sh = {64'b0, pp};
            2'd1:    pp_sh = {32'b0, pp, 32'b0};
            2'd2:    pp_sh = {pp, 64'b0};
            default: pp_sh = '0;
        endcase
    end

    assign x2_mag = x2_reg[47] ? 64'(-66'(x2_reg)) : 64'(x2_reg);
    assign y_mag  = y_reg[63] ? 64'(-y_reg) : 64'(y_reg);
    assign a_mag  = a_reg[63] ? 64'(-a_reg) : 64'(a_reg);
    assign fh_mag = fh_reg[47] ? 64'(-66'(fh_reg)) : 64'(fh_reg);

    assign t_c = (y_mag > 64'(WLIM >>> 3)) ? WLIM
               : clampw(66'(d_reg) + 66'({y_mag[60:0], 3'b000}));

    // digit-by-digit root, two radicand bits a step
    assign sq_rem   = {rem_reg[65:0], acc_reg[127:126]};
    assign sq_trial = {2'b00, root_reg, 2'b01};

    // long division, numerator bits first, then fraction zeros
    assign dv_bit = cmd.tail ? 1'b0 : q_reg[63];
    assign dv_rem = {rem_reg[66:0], dv_bit};
    assign dv_ge  = (dv_rem >= 68'(d_reg));

    assign a_half_dif = (66'(root_reg) - 66'(d_reg)) >>> 1;
    assign a_term = (y_reg > 0) ? a_half_dif : ((y_reg < 0) ? -a_half_dif : 66'sd0);
    assign fsy    = (d_reg != '0) && (y_mag < d_reg);
    assign fsa    = (d_reg != '0) && (a_mag < d_reg);

    always_comb
    begin
        if (fsa)
            fh_w = (a_reg > 0) ? -$signed(q_reg) : $signed(q_reg);
        else if (a_reg > 0)
            fh_w = -$signed(64'(speed_reg) << FRAC_BITS);
        else if (a_reg < 0)
            fh_w = $signed(64'(speed_reg) << FRAC_BITS);
        else
            fh_w = '0;
    end

    assign stat.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        x1_next        = x1_reg;
        x2_next        = x2_reg;
        out_valid_next = out_valid_reg && out_stall;
        v_next         = v_reg;
        h0_next        = h0_reg;
        d_next         = d_reg;
        a0_next        = a0_reg;
        y_next         = y_reg;
        a_next         = a_reg;
        fh_next        = fh_reg;
        x1n_next       = x1n_reg;
        acc_next       = acc_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        root_next      = root_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        tv_next        = tv_reg;
        tr_next        = tr_reg;
        ac_next        = ac_reg;
        sum_w          = '0;
        case (cmd.op)
            tdf_pkg::OP_LOAD:
            begin
                v_next   = target_value;
                h0_next  = h0_c;
                ma_next  = 64'(h0_c);
                mb_next  = 64'(h0_c);
                acc_next = '0;
            end
            tdf_pkg::OP_MUL:
            begin
                acc_next = acc_reg + pp_sh;
            end
            tdf_pkg::OP_HH:
            begin
                ma_next  = 64'(speed_reg);
                mb_next  = acc_reg[87:24];
                acc_next = '0;
            end
            tdf_pkg::OP_D:
            begin
                d_next   = 64'(acc_reg >> DSH);
                ma_next  = x2_mag;
                mb_next  = 64'(h0_reg);
                acc_next = '0;
            end
            tdf_pkg::OP_A0:
            begin
                a0_next = sat24(acc_reg, x2_reg[47]);
            end
            tdf_pkg::OP_Y:
            begin
                y_next = clampw(66'(x1_reg) - 66'(v_reg) + 66'(a0_reg));
            end
            tdf_pkg::OP_T:
            begin
                ma_next  = d_reg;
                mb_next  = t_c;
                acc_next = '0;
            end
            tdf_pkg::OP_SQI:
            begin
                rem_next  = '0;
                root_next = '0;
            end
            tdf_pkg::OP_SQ:
            begin
                acc_next = {acc_reg[125:0], 2'b00};
                if (sq_rem >= sq_trial)
                begin
                    rem_next  = sq_rem - sq_trial;
                    root_next = {root_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next  = sq_rem;
                    root_next = {root_reg[62:0], 1'b0};
                end
            end
            tdf_pkg::OP_A:
            begin
                if (fsy)
                    a_next = clampw(66'(a0_reg) + 66'(y_reg));
                else
                    a_next = clampw(66'(a0_reg) + a_term);
            end
            tdf_pkg::OP_M:
            begin
                ma_next  = 64'(speed_reg);
                mb_next  = a_mag;
                acc_next = '0;
            end
            tdf_pkg::OP_DVI:
            begin
                q_next   = acc_reg[63:0];
                rem_next = '0;
            end
            tdf_pkg::OP_DV:
            begin
                rem_next = dv_ge ? dv_rem - 68'(d_reg) : dv_rem;
                q_next   = {q_reg[62:0], dv_ge};
            end
            tdf_pkg::OP_FH:
            begin
                if (66'(fh_w) > HI48)
                    fh_next = HI48[47:0];
                else if (66'(fh_w) < LO48)
                    fh_next = LO48[47:0];
                else
                    fh_next = fh_w[47:0];
                ma_next  = x2_mag;
                mb_next  = 64'(step_reg);
                acc_next = '0;
            end
            tdf_pkg::OP_X1:
            begin
                sum_w = 66'(x1_reg) + 66'(sat24(acc_reg, x2_reg[47]));
                if (sum_w > HI32)
                    x1n_next = HI32[31:0];
                else if (sum_w < LO32)
                    x1n_next = LO32[31:0];
                else
                    x1n_next = sum_w[31:0];
                ma_next  = fh_mag;
                mb_next  = 64'(step_reg);
                acc_next = '0;
            end
            tdf_pkg::OP_X2:
            begin
                sum_w = 66'(x2_reg) + 66'(sat24(acc_reg, fh_reg[47]));
                if (sum_w > HI48)
                    x2_next = HI48[47:0];
                else if (sum_w < LO48)
                    x2_next = LO48[47:0];
                else
                    x2_next = sum_w[47:0];
                x1_next        = x1n_reg;
                tv_next        = x1n_reg;
                tr_next        = x2_next;
                ac_next        = fh_reg;
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg     <= tdf_pkg::SPEED_RST;
            step_reg      <= tdf_pkg::STEP_RST;
            filter_reg    <= tdf_pkg::FILTER_RST;
            x1_reg        <= '0;
            x2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            x1_reg        <= x1_next;
            x2_reg        <= x2_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    tdf_pkg::REG_SPEED:  speed_reg  <= cfg_data[19:0];
                    tdf_pkg::REG_STEP:   step_reg   <= cfg_data[23:0];
                    tdf_pkg::REG_FILTER: filter_reg <= cfg_data[3:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        h0_reg   <= h0_next;
        d_reg    <= d_next;
        a0_reg   <= a0_next;
        y_reg    <= y_next;
        a_reg    <= a_next;
        fh_reg   <= fh_next;
        x1n_reg  <= x1n_next;
        acc_reg  <= acc_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        tv_reg   <= tv_next;
        tr_reg   <= tr_next;
        ac_reg   <= ac_next;
    end

    assign out_valid     = out_valid_reg;
    assign tracked_value = tv_reg;
    assign tracked_rate  = tr_reg;
    assign acceleration  = ac_reg;

endmodule

/* rtl/tracking_differentiator_fhan.sv */
// The input stalls until the sequencer is back in idle, so a new word is taken only
// once the last one is finished. Each word's run is set by the 64-step root, the
// (64 + FRAC_BITS)-step divider and seven passes through the shared 32x32 multiplier.
// Reset: asynchronous, active low; tracker state clears to zero and the
// configuration registers return to r = 200, h = 0.014, N0 = 5.
module tracking_differentiator_fhan #(
    parameter int FRAC_BITS = tdf_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [31:0]             target_value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [31:0]             tracked_value,
    output logic signed [47:0]             tracked_rate,
    output logic signed [47:0]             acceleration,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tdf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tdf_pkg::CFG_DATA_W-1:0] cfg_data
);

    tdf_pkg::cmd_t  cmd;
    tdf_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    tdf_ctrl #(
        .FRAC_BITS(FRAC_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    tdf_datapath #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .target_value  (target_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .tracked_value (tracked_value),
        .tracked_rate  (tracked_rate),
        .acceleration  (acceleration)
    );

    // a word taken in always leaves the sequencer busy
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("sequencer not busy after input word");

    // a load command only with an accepted word
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == tdf_pkg::OP_LOAD |-> in_valid && !in_stall)
        else $error("load issued without accepted word");

    // a new result appears only at the end of a busy period
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall) && !in_stall)
        else $error("result raised outside finishing step");

endmodule

/* tb/sv/tb_tracking_differentiator_fhan.sv */
module tb_tracking_differentiator_fhan;

    localparam int     FB        = 16;
    localparam longint WIDE_LIM  = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam longint S48_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint S48_MIN   = -S48_MAX - 1;
    localparam longint S32_MAX   = 64'sh0000_0000_7FFF_FFFF;
    localparam longint S32_MIN   = -S32_MAX - 1;
    localparam int     MAX_CYCLES = 4000000;

    typedef struct {
        logic signed [31:0] pos;
        logic signed [47:0] rate;
        logic signed [47:0] accel;
    } track_t;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic signed [31:0]              target_value;
    logic                            out_valid;
    logic                            out_stall;
    logic signed [31:0]              tracked_value;
    logic signed [47:0]              tracked_rate;
    logic signed [47:0]              acceleration;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [tdf_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [tdf_pkg::CFG_DATA_W-1:0]  cfg_data;

    // tracker copy kept alongside the block
    longint    pos_est;
    longint    rate_est;
    bit [63:0] speed;
    bit [63:0] step;
    bit [63:0] n0;

    track_t pending_tracks[$];
    int     errors;
    int     cycles;
    int     hold_req;
    int     burst_left;

    tracking_differentiator_fhan uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .target_value  (target_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .tracked_value (tracked_value),
        .tracked_rate  (tracked_rate),
        .acceleration  (acceleration),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic longint sat(longint v, longint lo, longint hi);
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint sgn_of(longint v);
        return v > 0 ? 64'sd1 : (v < 0 ? -64'sd1 : 64'sd0);
    endfunction

    function automatic bit [63:0] abs_of(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // magnitude times a Q0.24 factor, truncated toward zero, saturated
    function automatic longint scale_q24(longint a, bit [63:0] b);
        bit [127:0] p;
        p = 128'(abs_of(a)) * 128'(b);
        p = p >> 24;
        if (p > 128'(WIDE_LIM))
            p = 128'(WIDE_LIM);
        return a < 0 ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic bit [63:0] root_floor(bit [127:0] n);
        bit [63:0] res;
        bit [63:0] c;
        res = '0;
        for (int i = 62; i >= 0; i--)
        begin
            c = res | (64'd1 << i);
            if (128'(c) * 128'(c) <= n)
                res = c;
        end
        return res;
    endfunction

    function automatic track_t advance_tracker(logic signed [31:0] v);
        longint    x1, x2, vv, d, a0, y, t, a1, a2, a, fh, x1n, x2n;
        bit [63:0] h0, yabs, aabs, m, q, rm;
        bit        fsy, fsa;
        track_t    e;
        x1 = pos_est;
        x2 = rate_est;
        vv = longint'(v);
        h0 = n0 * step;
        d  = longint'((speed * ((h0 * h0) >> 24)) >> (24 - FB));
        a0 = scale_q24(x2, h0);
        y  = sat(x1 - vv + a0, -WIDE_LIM, WIDE_LIM);
        yabs = abs_of(y);
        if (yabs > 64'(WIDE_LIM >>> 3))
            t = WIDE_LIM;
        else
            t = sat(d + longint'(yabs << 3), -WIDE_LIM, WIDE_LIM);
        a1 = longint'(root_floor(128'(64'(d)) * 128'(64'(t))));
        a2 = sat(a0 + sgn_of(y) * ((a1 - d) >>> 1), -WIDE_LIM, WIDE_LIM);
        fsy = d > 0 && yabs < 64'(d);
        a = fsy ? sat(a0 + y, -WIDE_LIM, WIDE_LIM) : a2;
        aabs = abs_of(a);
        fsa = d > 0 && aabs < 64'(d);
        if (fsa)
        begin
            // linear zone: r*a/d with FB fraction bits, 64-bit wrap on r*|a|
            m  = speed * aabs;
            q  = m / 64'(d);
            rm = m % 64'(d);
            for (int i = 0; i < FB; i++)
            begin
                rm = rm << 1;
                q  = q << 1;
                if (rm >= 64'(d))
                begin
                    rm = rm - 64'(d);
                    q  = q | 64'd1;
                end
            end
            fh = a > 0 ? -longint'(q) : longint'(q);
        end
        else
            fh = -sgn_of(a) * longint'(speed << FB);
        fh  = sat(fh, S48_MIN, S48_MAX);
        x1n = sat(x1 + scale_q24(x2, step), S32_MIN, S32_MAX);
        x2n = sat(x2 + scale_q24(fh, step), S48_MIN, S48_MAX);
        pos_est  = x1n;
        rate_est = x2n;
        e.pos   = x1n[31:0];
        e.rate  = x2n[47:0];
        e.accel = fh[47:0];
        return e;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    always @(posedge clk)
    begin
        track_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_tracks.size() == 0)
                report_mismatch("result word with nothing expected");
            else
            begin
                e = pending_tracks.pop_front();
                if (tracked_value !== e.pos)
                    report_mismatch($sformatf("tracked_value %h, want %h",
                                              tracked_value, e.pos));
                if (tracked_rate !== e.rate)
                    report_mismatch($sformatf("tracked_rate %h, want %h",
                                              tracked_rate, e.rate));
                if (acceleration !== e.accel)
                    report_mismatch($sformatf("acceleration %h, want %h",
                                              acceleration, e.accel));
            end
        end
    end

    // receiver: long hold-offs on request, otherwise a changing stall pattern
    initial
    begin
        int mode;
        int mode_left;
        mode = 0;
        mode_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(200, 2000);
            end
            mode_left--;
            if (hold_req > 0)
            begin
                out_stall <= 1'b1;
                hold_req--;
            end
            else if (mode == 0)
                out_stall <= 1'b0;
            else if (mode == 1)
                out_stall <= ($urandom_range(0, 3) == 0);
            else
                out_stall <= $urandom_range(0, 1);
        end
    end

    // leaves in_valid high so a burst continues without a gap
    task automatic send_word(logic signed [31:0] v);
        in_valid     <= 1'b1;
        target_value <= v;
        do
            @(posedge clk);
        while (in_stall);
        pending_tracks.push_back(advance_tracker(v));
    endtask

    task automatic offer(logic signed [31:0] v);
        send_word(v);
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 300)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_tracks.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [tdf_pkg::CFG_IDX_W-1:0] idx,
                             logic [tdf_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            tdf_pkg::REG_SPEED:  speed = 64'(data[19:0]);
            tdf_pkg::REG_STEP:   step  = 64'(data[23:0]);
            tdf_pkg::REG_FILTER: n0    = 64'(data[3:0]);
            default: ;
        endcase
    endtask

    task automatic load_settings(logic [tdf_pkg::CFG_DATA_W-1:0] s,
                                 logic [tdf_pkg::CFG_DATA_W-1:0] h,
                                 logic [tdf_pkg::CFG_DATA_W-1:0] n);
        settle();
        write_reg(tdf_pkg::REG_SPEED, s);
        write_reg(tdf_pkg::REG_STEP, h);
        write_reg(tdf_pkg::REG_FILTER, n);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic play_sequences(int n);
        int sent;
        int len;
        int base;
        int slope;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                offer($urandom);
                sent++;
            end
            else
            begin
                // held or ramping target, the tracker settles into the linear zone
                len   = $urandom_range(5, 40);
                base  = $signed($urandom) >>> $urandom_range(0, 16);
                slope = $urandom_range(0, 2) == 0 ? 0
                        : $signed($urandom) >>> $urandom_range(12, 31);
                for (int j = 0; j < len; j++)
                    offer(base + slope * j);
                sent += len;
            end
        end
    endtask

    task automatic test_directed_defaults();
        offer(32'sd0);
        offer(32'sh7FFF_FFFF);
        offer(32'sh8000_0000);
        offer(32'sd1);
        offer(-32'sd1);
        repeat (12) offer(32'sh0001_0000);
        repeat (4) offer(32'sd0);
    endtask

    task automatic test_extreme_settings();
        load_settings(24'hF_FFFF, 24'hFF_FFFF, 24'hF);
        offer(32'sh7FFF_FFFF);
        offer(32'sh8000_0000);
        offer(32'sd0);
        play_sequences(250);
        // tiny step gives a zero band
        load_settings(24'd1, 24'd1, 24'd1);
        offer(32'sh7FFF_FFFF);
        offer(32'sh8000_0000);
        play_sequences(150);
        // bits above the register width are dropped
        load_settings(24'hFF_FFFF, 24'd234881, 24'hFF);
        play_sequences(100);
    endtask

    task automatic test_backpressure();
        settle();
        hold_req = 3000;
        for (int i = 0; i < 8; i++)
            send_word($urandom);
        settle();
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 6; p++)
        begin
            load_settings(24'($urandom_range(0, 1) ? $urandom_range(1, 2000)
                                                   : $urandom_range(1, 1048575)),
                          24'($urandom_range(0, 1) ? $urandom_range(1, 1000000)
                                                   : $urandom_range(1, 16777215)),
                          24'($urandom_range(1, 15)));
            play_sequences(230);
        end
        load_settings(24'(tdf_pkg::SPEED_RST), 24'(tdf_pkg::STEP_RST),
                      24'(tdf_pkg::FILTER_RST));
        play_sequences(100);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        target_value = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        errors       = 0;
        cycles       = 0;
        hold_req     = 0;
        burst_left   = 5;
        pos_est      = 0;
        rate_est     = 0;
        speed        = 64'(tdf_pkg::SPEED_RST);
        step         = 64'(tdf_pkg::STEP_RST);
        n0           = 64'(tdf_pkg::FILTER_RST);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_defaults();
        play_sequences(200);
        test_backpressure();
        test_extreme_settings();
        test_random_settings();

        settle();
        repeat (250) @(posedge clk);
        if (errors == 0 && pending_tracks.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
